// ----- rtl/iort_pkg.sv -----
`default_nettype none

package iort_pkg;

  localparam int unsigned DEF_WINDOW = 64;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOCK   = 2'd0,
    CMD_UNLOCK = 2'd1,
    CMD_BYPASS = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ORDER  = 2'd2,
    ST_BEYOND = 2'd3
  } status_e;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_INC = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e         op;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
  } alu_req_t;

endpackage

`default_nettype wire

// ----- rtl/in_order_release_tracker.sv -----
`default_nettype none

// Channel   Dir  tdata                                   tuser
// s_axis    in   [31:0] order_id                         [1:0] command
// m_axis    out  [0] granted, [2:1] status,              -
//                [34:3] next_expected, [39:35] zero
//
// States: lock, unlock out of order and drops pass EVAL and FIN; a bypass into the window
// adds MRD; an advance runs ADV and ACHK per id released, at most one mark read and one
// mark write per cycle. After reset all marks are cleared before the first word is taken.
// A finished result sits in the output register; the next word may be taken meanwhile,
// and the sequencer waits at its end only while that register is still full.
module in_order_release_tracker #(
  parameter int unsigned WINDOW = iort_pkg::DEF_WINDOW
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [iort_pkg::ID_W-1:0]         s_axis_tdata,   // [31:0] order_id
  input  wire logic [iort_pkg::CMD_W-1:0]        s_axis_tuser,   // [1:0] command
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [iort_pkg::OUT_DATA_W-1:0]        m_axis_tdata    // granted, status, next_expected
);

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [IDX_W-1:0]          LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [IDX_W:0]            WIN_S    = (IDX_W+1)'(WINDOW);
  localparam logic [iort_pkg::ID_W-1:0] WIN_ID   = iort_pkg::ID_W'(WINDOW);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_MRD   = 7'b0001000,
    S_ADV   = 7'b0010000,
    S_ACHK  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e                         state_q, state_d;
  logic [IDX_W-1:0]               clr_q, clr_d;
  logic [IDX_W-1:0]               head_q, head_d;
  logic [IDX_W-1:0]               slot_q, slot_d;
  logic [iort_pkg::ID_W-1:0]      next_q, next_d;
  iort_pkg::cmd_e                 cmd_q;
  logic [iort_pkg::ID_W-1:0]      id_q;
  logic                           gnt_q, gnt_d;
  iort_pkg::status_e              st_q, st_d;
  logic                           out_valid_q, out_valid_d;
  logic [iort_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                           mem_q [WINDOW];
  logic                           rdata_q;
  logic                           mem_we;
  logic [IDX_W-1:0]               mem_waddr;
  logic                           mem_wdata;
  logic [IDX_W-1:0]               mem_raddr;

  iort_pkg::alu_req_t             alu_req;
  logic [iort_pkg::ID_W-1:0]      alu_res;

  logic                           below, equal, beyond;
  logic [IDX_W:0]                 slot_sum;
  logic [IDX_W-1:0]               slot_calc;
  logic [IDX_W-1:0]               head_inc;
  logic                           in_fire;
  logic                           out_free;

  iort_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign below    = alu_res[iort_pkg::ID_W-1];
  assign equal    = (alu_res == '0);
  assign beyond   = (alu_res >= WIN_ID);
  assign slot_sum = {1'b0, head_q} + {1'b0, alu_res[IDX_W-1:0]};
  assign slot_calc = (slot_sum >= WIN_S) ? IDX_W'(slot_sum - WIN_S) : slot_sum[IDX_W-1:0];
  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    head_d      = head_q;
    slot_d      = slot_q;
    next_d      = next_q;
    gnt_d       = gnt_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = head_q;
    mem_wdata   = 1'b0;
    mem_raddr   = slot_calc;
    alu_req.op  = iort_pkg::ALU_SUB;
    alu_req.a   = id_q;
    alu_req.b   = next_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        gnt_d  = 1'b0;
        st_d   = iort_pkg::ST_OK;
        slot_d = slot_calc;
        state_d = S_FIN;
        case (cmd_q)
          iort_pkg::CMD_LOCK: begin
            gnt_d = below || equal;
            if (below) begin
              st_d = iort_pkg::ST_DUP;
            end
          end
          iort_pkg::CMD_UNLOCK: begin
            if (equal) begin
              state_d = S_ADV;
            end else begin
              st_d = iort_pkg::ST_ORDER;
            end
          end
          iort_pkg::CMD_BYPASS: begin
            if (below) begin
              st_d = iort_pkg::ST_DUP;
            end else if (equal) begin
              state_d = S_ADV;
            end else if (beyond) begin
              st_d = iort_pkg::ST_BEYOND;
            end else begin
              state_d = S_MRD;
            end
          end
          default: ;
        endcase
      end
      S_MRD: begin
        if (rdata_q) begin
          st_d = iort_pkg::ST_DUP;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = slot_q;
          mem_wdata = 1'b1;
        end
        state_d = S_FIN;
      end
      S_ADV: begin
        // old head slot becomes the far end of the window: clear it
        mem_we     = 1'b1;
        mem_waddr  = head_q;
        mem_raddr  = head_inc;
        head_d     = head_inc;
        alu_req.op = iort_pkg::ALU_INC;
        alu_req.a  = next_q;
        next_d     = alu_res;
        state_d    = S_ACHK;
      end
      S_ACHK: begin
        state_d = rdata_q ? S_ADV : S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {{(iort_pkg::OUT_DATA_W-35){1'b0}}, next_q, st_q, gnt_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      next_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      next_q      <= next_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= iort_pkg::cmd_e'(s_axis_tuser);
      id_q  <= s_axis_tdata;
    end
    slot_q     <= slot_d;
    gnt_q      <= gnt_d;
    st_q       <= st_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/iort_alu.sv -----
`default_nettype none

// Shared 32-bit adder: a - b for the serial-number distance, a + 1 for the commit pointer.
module iort_alu (
  input  iort_pkg::alu_req_t            req_i,
  output logic [iort_pkg::ID_W-1:0]     res_o
);

  logic [iort_pkg::ID_W-1:0] opb;
  logic                      cin;

  always_comb begin
    unique case (req_i.op)
      iort_pkg::ALU_SUB: begin
        opb = ~req_i.b;
        cin = 1'b1;
      end
      iort_pkg::ALU_INC: begin
        opb = '0;
        cin = 1'b1;
      end
      default: begin
        opb = '0;
        cin = 1'b0;
      end
    endcase
  end

  assign res_o = req_i.a + opb + {{(iort_pkg::ID_W-1){1'b0}}, cin};

endmodule

`default_nettype wire

// ----- tb/sv/in_order_release_tracker_test.sv -----
`timescale 1ns / 100ps

module in_order_release_tracker_test;
  import iort_pkg::*;

  localparam int unsigned WIN = DEF_WINDOW;

  typedef struct packed {
    logic            granted;
    status_e         status;
    logic [ID_W-1:0] next_exp;
  } reply_t;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [ID_W-1:0]       s_tdata  = '0;
  logic [CMD_W-1:0]      s_tuser  = CMD_LOCK;
  logic                  m_tready = 1'b0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire [OUT_DATA_W-1:0]  m_tdata;

  reply_t          reply_q[$];
  logic [ID_W-1:0] exp_next_id = '0;
  logic [WIN-1:0]  exp_marks   = '0;
  int              err_cnt     = 0;
  bit              no_idle     = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_order_release_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  // step past the expected id, then over every consecutive skip mark
  function automatic void release_run();
    int n;
    n = 0;
    exp_next_id = exp_next_id + 1;
    exp_marks   = exp_marks >> 1;
    while (exp_marks[0] && n < WIN) begin
      exp_next_id = exp_next_id + 1;
      exp_marks   = exp_marks >> 1;
      n++;
    end
  endfunction

  function automatic reply_t track_command(cmd_e cmd, logic [ID_W-1:0] id);
    logic [ID_W-1:0] d;
    reply_t          r;
    d         = id - exp_next_id;
    r.granted = 1'b0;
    r.status  = ST_OK;
    case (cmd)
      CMD_LOCK: begin
        if (d[ID_W-1]) begin
          r.granted = 1'b1;
          r.status  = ST_DUP;
        end else if (d == 0) begin
          r.granted = 1'b1;
        end
      end
      CMD_UNLOCK: begin
        if (d == 0) release_run();
        else r.status = ST_ORDER;
      end
      CMD_BYPASS: begin
        if (d[ID_W-1]) r.status = ST_DUP;
        else if (d == 0) release_run();
        else if (d >= WIN) r.status = ST_BEYOND;
        else if (exp_marks[d]) r.status = ST_DUP;
        else exp_marks[d] = 1'b1;
      end
      default: ;
    endcase
    r.next_exp = exp_next_id;
    return r;
  endfunction

  task automatic send_word(cmd_e cmd, logic [ID_W-1:0] id);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= id;
    s_tuser  <= cmd;
    do @(posedge clk_i); while (s_tready !== 1'b1);
    reply_q = {reply_q, track_command(cmd, id)};
  endtask

  always begin
    int     stall;
    reply_t want;
    stall = no_idle ? 0 : $urandom_range(0, 4);
    if (stall > 0) begin
      m_tready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
    m_tready <= 1'b1;
    do @(posedge clk_i); while (m_tvalid !== 1'b1);
    if (reply_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
      err_cnt++;
    end else begin
      want = reply_q.pop_front();
      if (m_tdata[0] !== want.granted) begin
        $display("%0t: granted expected %b actual %b", $time, want.granted, m_tdata[0]);
        err_cnt++;
      end
      if (m_tdata[2:1] !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, m_tdata[2:1]);
        err_cnt++;
      end
      if (m_tdata[34:3] !== want.next_exp) begin
        $display("%0t: next_expected expected %h actual %h", $time, want.next_exp,
                 m_tdata[34:3]);
        err_cnt++;
      end
      if (m_tdata[39:35] !== '0) begin
        $display("%0t: pad bits expected 0 actual %b", $time, m_tdata[39:35]);
        err_cnt++;
      end
    end
  end

  // edges of the serial compare, every command, marks, duplicates, chained release
  task automatic test_directed();
    send_word(CMD_LOCK, 32'h0000_0000);
    send_word(CMD_LOCK, 32'h0000_0001);
    send_word(CMD_LOCK, 32'hFFFF_FFFF);
    send_word(CMD_LOCK, 32'h8000_0000);
    send_word(CMD_LOCK, 32'h7FFF_FFFF);
    send_word(CMD_UNLOCK, 32'd5);
    send_word(CMD_NONE, 32'hFFFF_FFFF);
    send_word(CMD_UNLOCK, 32'd0);
    send_word(CMD_BYPASS, 32'd0);
    send_word(CMD_BYPASS, 32'd3);
    send_word(CMD_BYPASS, 32'd3);
    send_word(CMD_BYPASS, WIN);
    send_word(CMD_BYPASS, WIN + 1);
    send_word(CMD_BYPASS, 32'h8000_0000);
    send_word(CMD_BYPASS, 32'hFFFF_FFFF);
    send_word(CMD_BYPASS, 32'd2);
    send_word(CMD_LOCK, 32'd3);
    send_word(CMD_BYPASS, 32'd1);
    send_word(CMD_LOCK, 32'd2);
    send_word(CMD_UNLOCK, 32'd3);
    send_word(CMD_UNLOCK, 32'd4);
    send_word(CMD_NONE, 32'h0000_0000);
  endtask

  // fill the whole window in random order, then release it in one run
  task automatic test_full_window();
    int unsigned     offs[WIN-1];
    int unsigned     tmp;
    int              j;
    logic [ID_W-1:0] base;
    base = exp_next_id;
    for (int i = 0; i < WIN - 1; i++) offs[i] = i + 1;
    for (int i = WIN - 2; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = offs[i];
      offs[i] = offs[j];
      offs[j] = tmp;
    end
    no_idle = 1'b1;
    for (int i = 0; i < WIN - 1; i++) send_word(CMD_BYPASS, base + offs[i]);
    no_idle = 1'b0;
    send_word(CMD_BYPASS, base + WIN - 1);
    send_word(CMD_BYPASS, base + WIN);
    send_word(CMD_LOCK, base + 1);
    send_word(CMD_UNLOCK, base);
    send_word(CMD_LOCK, base + WIN);
  endtask

  task automatic test_random();
    cmd_e            cmd;
    logic [ID_W-1:0] id;
    int unsigned     r;
    for (int i = 0; i < 960; i++) begin
      no_idle = ((i / 120) % 3 == 2);
      r = $urandom_range(0, 99);
      if (r < 25) begin
        cmd = (r < 15) ? CMD_UNLOCK : CMD_BYPASS;
        id  = exp_next_id;
      end else if (r < 50) begin
        cmd = CMD_BYPASS;
        id  = exp_next_id + $urandom_range(1, WIN - 1);
      end else if (r < 57) begin
        cmd = CMD_BYPASS;
        id  = exp_next_id + ((r < 54) ? $urandom_range(WIN, WIN + 8)
                                      : $urandom_range(WIN, 32'h7FFF_FFFF));
      end else if (r < 72) begin
        cmd = CMD_LOCK;
        id  = exp_next_id + $urandom_range(0, 6) - 3;
      end else if (r < 87) begin
        cmd = cmd_e'($urandom_range(0, 3));
        id  = $urandom;
      end else if (r < 93) begin
        cmd = CMD_UNLOCK;
        id  = exp_next_id + $urandom_range(1, WIN);
      end else begin
        cmd = cmd_e'($urandom_range(0, 2));
        id  = exp_next_id - $urandom_range(1, 200);
      end
      send_word(cmd, id);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_window();
    test_random();
    s_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
